/* rtl/pcd_pkg.sv */
// Shared constants, types and codes of the page cache directory.
package pcd_pkg;

    localparam int SLOT_BITS   = 6;
    localparam int SLOTS       = 1 << SLOT_BITS;
    localparam int PTR_W       = SLOT_BITS + 1;
    localparam int BUCKET_BITS = 7;
    localparam int BUCKETS     = 1 << BUCKET_BITS;

    localparam int PAGE_W  = 32;
    localparam int PINS_W  = 16;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    localparam int SLOTO_W = 6;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 64;

    localparam logic [PTR_W-1:0]  NIL     = PTR_W'(SLOTS);
    localparam logic [PINS_W-1:0] PIN_MAX = '1;

    localparam logic [OP_W-1:0] OP_GET   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNPIN = 2'd1;
    localparam logic [OP_W-1:0] OP_DIRTY = 2'd2;

    localparam logic [STAT_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FREE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_REPL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_ALLPIN = 3'd3;
    localparam logic [STAT_W-1:0] ST_DONE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTP   = 3'd5;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOTO_W-1:0] slot_index;
        logic               writeback;
        logic [PAGE_W-1:0]  victim_page_id;
        logic [PINS_W-1:0]  pins_after;
        logic               dirty_after;
    } t_res;

endpackage

/* rtl/page_cache_directory_lru_pin_top.sv */
// Top level of the page cache directory: stream ports and result register.
//
//  channel | direction | fields
//  s       | in        | tdata: op[1:0], page_id[33:2]
//  m       | out       | tdata: status, slot_index, writeback, victim_page_id,
//          |           |        pins_after, dirty_after
//
// A request probes the buckets one after another; every one of the BUCKETS
// buckets is probed unless the page is found, and a miss on a full directory
// then walks the LRU chain from the tail for a victim before the updates.
// The single read port of the slot memories makes each probe and chain step wait for its read.
// Reset clears the LRU head and tail, the fill count and the bucket valid bits.
// A finished result waits in the output register while the next request is taken.
module page_cache_directory_lru_pin_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [pcd_pkg::IN_W-1:0]   i_s_tdata,  // op, page_id, zero pad
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [pcd_pkg::OUT_W-1:0]  o_m_tdata   // status, slot_index, writeback,
                                                   // victim_page_id, pins_after,
                                                   // dirty_after, zero pad
);
    import pcd_pkg::*;

    logic r_out_valid;
    t_res r_out;
    logic busy, done, out_free;
    t_res res;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !busy;

    pcd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_s_tvalid && !busy),
        .i_op       (i_s_tdata[OP_W-1:0]),
        .i_page     (i_s_tdata[OP_W+PAGE_W-1:OP_W]),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_done     (done),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.dirty_after, r_out.pins_after, r_out.victim_page_id,
                         r_out.writeback, r_out.slot_index, r_out.status};
endmodule

/* rtl/pcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcd_ram #(
    parameter int WIDTH = 8,
    parameter int ABITS = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [1<<ABITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

/* rtl/pcd_seq.sv */
// Sequencer of the directory: bucket probing, LRU chain walk and updates.
module pcd_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pcd_pkg::OP_W-1:0]    i_op,
    input  logic [pcd_pkg::PAGE_W-1:0]  i_page,
    input  logic                        i_out_free,
    output logic                        o_busy,
    output logic                        o_done,
    output pcd_pkg::t_res               o_res
);
    import pcd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PBKT = 4'd1;
    localparam logic [3:0] S_PCMP = 4'd2;
    localparam logic [3:0] S_DISP = 4'd3;
    localparam logic [3:0] S_WISS = 4'd4;
    localparam logic [3:0] S_WCHK = 4'd5;
    localparam logic [3:0] S_UNLK = 4'd6;
    localparam logic [3:0] S_INS  = 4'd7;
    localparam logic [3:0] S_PSH1 = 4'd8;
    localparam logic [3:0] S_PSH2 = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]             r_state, n_state;
    logic [OP_W-1:0]        r_op, n_op;
    logic [PAGE_W-1:0]      r_page, n_page;
    logic [BUCKET_BITS-1:0] r_home, n_home;
    logic [BUCKET_BITS-1:0] r_b, n_b;
    logic [BUCKET_BITS-1:0] r_cnt, n_cnt;
    logic [BUCKET_BITS-1:0] r_fe, n_fe;
    logic                   r_fe_ok, n_fe_ok;
    logic                   r_found, n_found;
    logic                   r_miss, n_miss;
    logic [SLOT_BITS-1:0]   r_s, n_s;
    logic [BUCKET_BITS-1:0] r_bn, n_bn;
    logic [PTR_W-1:0]       r_cur, n_cur;
    logic [SLOT_BITS:0]     r_steps, n_steps;
    logic [PTR_W-1:0]       r_head, n_head;
    logic [PTR_W-1:0]       r_tail, n_tail;
    logic [SLOT_BITS:0]     r_filled, n_filled;
    logic [BUCKETS-1:0]     r_valid, n_valid;
    t_res                   r_res, n_res;

    // Slot memory controls.
    logic                   slot_re;
    logic [SLOT_BITS-1:0]   slot_ra;
    logic                   page_we, pins_we, dirty_we, prev_we, next_we, sbkt_we;
    logic [SLOT_BITS-1:0]   page_wa, pins_wa, dirty_wa, prev_wa, next_wa, sbkt_wa;
    logic [PINS_W-1:0]      pins_wd;
    logic                   dirty_wd;
    logic [PTR_W-1:0]       prev_wd, next_wd;
    logic [PAGE_W-1:0]      page_q;
    logic [PINS_W-1:0]      pins_q;
    logic                   dirty_q;
    logic [PTR_W-1:0]       prev_q, next_q;
    logic [BUCKET_BITS-1:0] sbkt_q;

    // Bucket table controls.
    logic                   bkt_re, bkt_we;
    logic [BUCKET_BITS-1:0] bkt_ra, bkt_wa;
    logic [SLOT_BITS-1:0]   bkt_q;

    logic [BUCKET_BITS-1:0] b_inc;
    logic [BUCKET_BITS-1:0] fe_dist, vb_dist;
    logic [PINS_W-1:0]      pins_up, pins_dn;

    pcd_ram #(.WIDTH(PAGE_W), .ABITS(SLOT_BITS)) u_page (
        .i_clk(i_clk), .i_we(page_we), .i_waddr(page_wa), .i_wdata(r_page),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(page_q));
    pcd_ram #(.WIDTH(PINS_W), .ABITS(SLOT_BITS)) u_pins (
        .i_clk(i_clk), .i_we(pins_we), .i_waddr(pins_wa), .i_wdata(pins_wd),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(pins_q));
    pcd_ram #(.WIDTH(1), .ABITS(SLOT_BITS)) u_dirty (
        .i_clk(i_clk), .i_we(dirty_we), .i_waddr(dirty_wa), .i_wdata(dirty_wd),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(dirty_q));
    pcd_ram #(.WIDTH(PTR_W), .ABITS(SLOT_BITS)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(prev_q));
    pcd_ram #(.WIDTH(PTR_W), .ABITS(SLOT_BITS)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(next_q));
    pcd_ram #(.WIDTH(BUCKET_BITS), .ABITS(SLOT_BITS)) u_sbkt (
        .i_clk(i_clk), .i_we(sbkt_we), .i_waddr(sbkt_wa), .i_wdata(r_bn),
        .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(sbkt_q));
    pcd_ram #(.WIDTH(SLOT_BITS), .ABITS(BUCKET_BITS)) u_bkt (
        .i_clk(i_clk), .i_we(bkt_we), .i_waddr(bkt_wa), .i_wdata(r_s),
        .i_re(bkt_re), .i_raddr(bkt_ra), .o_rdata(bkt_q));

    assign b_inc   = r_b + 1'b1;
    assign fe_dist = r_fe - r_home;
    assign vb_dist = sbkt_q - r_home;
    assign pins_up = (pins_q == PIN_MAX) ? pins_q : pins_q + 1'b1;
    assign pins_dn = (pins_q == '0) ? pins_q : pins_q - 1'b1;

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE) && i_out_free;
    assign o_res  = r_res;

    always_comb begin
        n_state = r_state;  n_op = r_op;        n_page = r_page;   n_home = r_home;
        n_b = r_b;          n_cnt = r_cnt;      n_fe = r_fe;       n_fe_ok = r_fe_ok;
        n_found = r_found;  n_miss = r_miss;    n_s = r_s;         n_bn = r_bn;
        n_cur = r_cur;      n_steps = r_steps;  n_head = r_head;   n_tail = r_tail;
        n_filled = r_filled; n_valid = r_valid; n_res = r_res;
        slot_re = 1'b0;  slot_ra = r_s;
        page_we = 1'b0;  page_wa = r_s;
        pins_we = 1'b0;  pins_wa = r_s;  pins_wd = '0;
        dirty_we = 1'b0; dirty_wa = r_s; dirty_wd = 1'b0;
        prev_we = 1'b0;  prev_wa = r_s;  prev_wd = NIL;
        next_we = 1'b0;  next_wa = r_s;  next_wd = NIL;
        sbkt_we = 1'b0;  sbkt_wa = r_s;
        bkt_re = 1'b0;   bkt_ra = r_b;
        bkt_we = 1'b0;   bkt_wa = r_bn;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_page  = i_page;
                    n_home  = i_page[BUCKET_BITS-1:0];
                    n_b     = i_page[BUCKET_BITS-1:0];
                    n_cnt   = '0;
                    n_fe_ok = 1'b0;
                    n_found = 1'b0;
                    n_res   = '0;
                    bkt_re  = 1'b1;
                    bkt_ra  = i_page[BUCKET_BITS-1:0];
                    n_state = S_PBKT;
                end
            end
            S_PBKT, S_PCMP: begin
                if (r_state == S_PBKT && r_valid[r_b]) begin
                    slot_re = 1'b1;
                    slot_ra = bkt_q;
                    n_s     = bkt_q;
                    n_state = S_PCMP;
                end else if (r_state == S_PCMP && page_q == r_page) begin
                    n_found = 1'b1;
                    n_state = S_DISP;
                end else begin
                    if (r_state == S_PBKT && !r_fe_ok) begin
                        n_fe    = r_b;
                        n_fe_ok = 1'b1;
                    end
                    // Every bucket is probed; an empty one does not end the search.
                    if (r_cnt == BUCKET_BITS'(BUCKETS - 1)) begin
                        n_state = S_DISP;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_b     = b_inc;
                        bkt_re  = 1'b1;
                        bkt_ra  = b_inc;
                        n_state = S_PBKT;
                    end
                end
            end
            S_DISP: begin
                case (r_op)
                    OP_GET: begin
                        if (r_found) begin
                            pins_we = 1'b1;
                            pins_wd = pins_up;
                            n_res.status      = ST_HIT;
                            n_res.slot_index  = SLOTO_W'(r_s);
                            n_res.pins_after  = pins_up;
                            n_res.dirty_after = dirty_q;
                            n_miss  = 1'b0;
                            n_state = S_UNLK;
                        end else if (!r_filled[SLOT_BITS]) begin
                            if (r_fe_ok) begin
                                n_s      = r_filled[SLOT_BITS-1:0];
                                n_filled = r_filled + 1'b1;
                                n_bn     = r_fe;
                                n_res.status = ST_FREE;
                                n_state  = S_INS;
                            end else begin
                                n_res.status = ST_ALLPIN;
                                n_state  = S_DONE;
                            end
                        end else begin
                            n_cur   = r_tail;
                            n_steps = '0;
                            n_state = S_WISS;
                        end
                    end
                    OP_UNPIN, OP_DIRTY: begin
                        if (r_found) begin
                            n_res.status     = ST_DONE;
                            n_res.slot_index = SLOTO_W'(r_s);
                            if (r_op == OP_UNPIN) begin
                                pins_we = 1'b1;
                                pins_wd = pins_dn;
                                n_res.pins_after  = pins_dn;
                                n_res.dirty_after = dirty_q;
                            end else begin
                                dirty_we = 1'b1;
                                dirty_wd = 1'b1;
                                n_res.pins_after  = pins_q;
                                n_res.dirty_after = 1'b1;
                            end
                        end else begin
                            n_res.status = ST_NOTP;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        n_res.status = ST_NOTP;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WISS: begin
                if (!r_steps[SLOT_BITS] && !r_cur[SLOT_BITS]) begin
                    slot_re = 1'b1;
                    slot_ra = r_cur[SLOT_BITS-1:0];
                    n_state = S_WCHK;
                end else begin
                    n_res   = '0;
                    n_res.status = ST_ALLPIN;
                    n_state = S_DONE;
                end
            end
            S_WCHK: begin
                if (pins_q == '0) begin
                    n_s = r_cur[SLOT_BITS-1:0];
                    n_valid[sbkt_q] = 1'b0;
                    // The freed bucket competes with the first empty one in probe order.
                    n_bn = (r_fe_ok && fe_dist < vb_dist) ? r_fe : sbkt_q;
                    n_res.status         = ST_REPL;
                    n_res.writeback      = dirty_q;
                    n_res.victim_page_id = page_q;
                    n_miss  = 1'b1;
                    n_state = S_UNLK;
                end else begin
                    n_cur   = prev_q;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WISS;
                end
            end
            S_UNLK: begin
                if (!prev_q[SLOT_BITS]) begin
                    next_we = 1'b1;
                    next_wa = prev_q[SLOT_BITS-1:0];
                    next_wd = next_q;
                end else begin
                    n_head = next_q;
                end
                if (!next_q[SLOT_BITS]) begin
                    prev_we = 1'b1;
                    prev_wa = next_q[SLOT_BITS-1:0];
                    prev_wd = prev_q;
                end else begin
                    n_tail = prev_q;
                end
                n_state = r_miss ? S_INS : S_PSH1;
            end
            S_INS: begin
                page_we  = 1'b1;
                pins_we  = 1'b1;
                pins_wd  = PINS_W'(1);
                dirty_we = 1'b1;
                dirty_wd = 1'b0;
                sbkt_we  = 1'b1;
                bkt_we   = 1'b1;
                n_valid[r_bn]     = 1'b1;
                n_res.slot_index  = SLOTO_W'(r_s);
                n_res.pins_after  = PINS_W'(1);
                n_res.dirty_after = 1'b0;
                n_state  = S_PSH1;
            end
            S_PSH1: begin
                next_we = 1'b1;
                next_wd = r_head;
                prev_we = 1'b1;
                prev_wd = NIL;
                n_state = S_PSH2;
            end
            S_PSH2: begin
                if (!r_head[SLOT_BITS]) begin
                    prev_we = 1'b1;
                    prev_wa = r_head[SLOT_BITS-1:0];
                    prev_wd = {1'b0, r_s};
                end
                n_head = {1'b0, r_s};
                if (r_tail[SLOT_BITS]) begin
                    n_tail = {1'b0, r_s};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_filled <= '0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_filled <= n_filled;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;    r_page  <= n_page;  r_home  <= n_home;  r_b     <= n_b;
        r_cnt   <= n_cnt;   r_fe    <= n_fe;    r_fe_ok <= n_fe_ok; r_found <= n_found;
        r_miss  <= n_miss;  r_s     <= n_s;     r_bn    <= n_bn;    r_cur   <= n_cur;
        r_steps <= n_steps; r_res   <= n_res;
    end
endmodule

/* verif/page_cache_directory_lru_pin_top_test.sv */
// Self-checking testbench of the page cache directory with LRU replacement and pin counts.
module page_cache_directory_lru_pin_top_test;
    import pcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] page;
    } t_req;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata;   // op[1:0], page_id[33:2], zero pad
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_W-1:0]  o_m_tdata;   // status, slot_index, writeback, victim_page_id,
                                    // pins_after, dirty_after, zero pad

    page_cache_directory_lru_pin_top dut (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Shadow copy of the directory state.
    logic [PAGE_W-1:0] sh_page  [SLOTS];
    logic [PINS_W-1:0] sh_pins  [SLOTS];
    logic              sh_dirty [SLOTS];
    int                sh_prev  [SLOTS];
    int                sh_next  [SLOTS];
    int                sh_bucket[BUCKETS];
    int                sh_head, sh_tail, sh_filled;

    t_req   pending_reqs[$];
    t_res   expected_res[$];
    int     fail_count;
    bit     hold_sender;

    function automatic void lru_unlink(int s);
        if (sh_prev[s] < SLOTS) sh_next[sh_prev[s]] = sh_next[s]; else sh_head = sh_next[s];
        if (sh_next[s] < SLOTS) sh_prev[sh_next[s]] = sh_prev[s]; else sh_tail = sh_prev[s];
    endfunction

    function automatic void lru_to_head(int s);
        sh_next[s] = sh_head;
        sh_prev[s] = SLOTS;
        if (sh_head < SLOTS) sh_prev[sh_head] = s;
        sh_head = s;
        if (sh_tail >= SLOTS) sh_tail = s;
    endfunction

    function automatic int find_bucket(logic [PAGE_W-1:0] page, int want);
        int home, b;
        home = page % BUCKETS;
        for (int i = 0; i < BUCKETS; i++) begin
            b = (home + i) % BUCKETS;
            if (want < 0 && sh_bucket[b] >= SLOTS) return b;
            if (want >= 0 && sh_bucket[b] == want) return b;
        end
        return BUCKETS;
    endfunction

    function automatic t_res predict_directory(t_req r);
        t_res res;
        int s, target, b, cur, vb;
        res = '0;
        res.status = ST_NOTP;
        s = SLOTS;
        for (int i = 0; i < BUCKETS; i++) begin
            b = (r.page % BUCKETS + i) % BUCKETS;
            if (sh_bucket[b] < SLOTS && sh_page[sh_bucket[b]] == r.page) begin
                s = sh_bucket[b];
                break;
            end
        end
        if (r.op == OP_GET && s < SLOTS) begin
            if (sh_pins[s] != PIN_MAX) sh_pins[s]++;
            lru_unlink(s);
            lru_to_head(s);
            res.status = ST_HIT; res.slot_index = SLOTO_W'(s);
            res.pins_after = sh_pins[s]; res.dirty_after = sh_dirty[s];
        end else if (r.op == OP_GET) begin
            target = SLOTS;
            b = BUCKETS;
            res.status = ST_ALLPIN;
            if (sh_filled < SLOTS) begin
                b = find_bucket(r.page, -1);
                if (b < BUCKETS) begin
                    target = sh_filled++;
                    res.status = ST_FREE;
                end
            end else begin
                cur = sh_tail;
                for (int k = 0; k < SLOTS && cur < SLOTS; k++) begin
                    if (sh_pins[cur] == 0) begin
                        vb = find_bucket(sh_page[cur], cur);
                        if (vb < BUCKETS) begin
                            sh_bucket[vb] = SLOTS;
                            lru_unlink(cur);
                            res.writeback = sh_dirty[cur];
                            res.victim_page_id = sh_page[cur];
                            target = cur;
                            res.status = ST_REPL;
                            break;
                        end
                    end
                    cur = sh_prev[cur];
                end
                b = find_bucket(r.page, -1);
            end
            if (target < SLOTS && b < BUCKETS) begin
                sh_page[target] = r.page; sh_pins[target] = 1; sh_dirty[target] = 1'b0;
                sh_bucket[b] = target;
                lru_to_head(target);
                res.slot_index = SLOTO_W'(target); res.pins_after = PINS_W'(1);
            end else begin
                res = '0;
                res.status = ST_ALLPIN;
            end
        end else if ((r.op == OP_UNPIN || r.op == OP_DIRTY) && s < SLOTS) begin
            if (r.op == OP_UNPIN) begin
                if (sh_pins[s] != 0) sh_pins[s]--;
            end else begin
                sh_dirty[s] = 1'b1;
            end
            res.status = ST_DONE; res.slot_index = SLOTO_W'(s);
            res.pins_after = sh_pins[s]; res.dirty_after = sh_dirty[s];
        end
        return res;
    endfunction

    // Acceptance of the driven item, seen at the rising edge.
    logic o_s_tready_q;
    always @(posedge i_clk) begin
        o_s_tready_q <= 1'b0;
        if (i_rst_n && i_s_tvalid && o_s_tready) o_s_tready_q <= 1'b1;
    end

    // Driver: bursts of transactions with random gaps.
    int burst_left, gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!(i_s_tvalid && !o_s_tready_q)) begin
            if (gap_left > 0 || hold_sender || pending_reqs.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_s_tvalid <= 1'b0;
            end else begin
                t_req r;
                r = pending_reqs.pop_front();
                i_s_tdata  <= {6'b0, r.page, r.op};
                i_s_tvalid <= 1'b1;
                expected_res.push_back(predict_directory(r));
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 30);
                end
            end
        end
    end

    // Receiver stall pattern: alternate runs of full readiness and random stalls.
    int stall_phase;
    always @(negedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 400;
        if (stall_phase < 150) i_m_tready <= 1'b1;
        else i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_res got, exp;
            got.status         = o_m_tdata[2:0];
            got.slot_index     = o_m_tdata[8:3];
            got.writeback      = o_m_tdata[9];
            got.victim_page_id = o_m_tdata[41:10];
            got.pins_after     = o_m_tdata[57:42];
            got.dirty_after    = o_m_tdata[58];
            if (expected_res.size() == 0) begin
                $error("Result transaction with no request outstanding");
                fail_count++;
            end else begin
                exp = expected_res.pop_front();
                if (got.status != exp.status) begin
                    $error("status: expected %0d, got %0d", exp.status, got.status);
                    fail_count++;
                end
                if (got.slot_index != exp.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", exp.slot_index, got.slot_index);
                    fail_count++;
                end
                if (got.writeback != exp.writeback) begin
                    $error("writeback: expected %0d, got %0d", exp.writeback, got.writeback);
                    fail_count++;
                end
                if (got.victim_page_id != exp.victim_page_id) begin
                    $error("victim_page_id: expected %0h, got %0h",
                           exp.victim_page_id, got.victim_page_id);
                    fail_count++;
                end
                if (got.pins_after != exp.pins_after) begin
                    $error("pins_after: expected %0d, got %0d", exp.pins_after, got.pins_after);
                    fail_count++;
                end
                if (got.dirty_after != exp.dirty_after) begin
                    $error("dirty_after: expected %0d, got %0d",
                           exp.dirty_after, got.dirty_after);
                    fail_count++;
                end
            end
        end
    end

    task automatic add_req(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page);
        t_req r;
        r.op = op;
        r.page = page;
        pending_reqs.push_back(r);
    endtask

    // Draws a page from a small working set so that hits and evictions are common;
    // a few draws use a full random identifier.
    function automatic logic [PAGE_W-1:0] pick_page(int span);
        if ($urandom_range(0, 19) == 0) return $urandom();
        return $urandom_range(0, span) * (($urandom_range(0, 3) == 0) ? BUCKETS : 1)
               + (($urandom_range(0, 7) == 0) ? 32'hFFFF_FF00 : 32'h0);
    endfunction

    initial begin
        logic [PAGE_W-1:0] pg;
        int span;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        stall_phase = 0;
        burst_left = 0;
        gap_left = 0;
        fail_count = 0;
        hold_sender = 1'b0;
        sh_head = SLOTS; sh_tail = SLOTS; sh_filled = 0;
        for (int i = 0; i < BUCKETS; i++) sh_bucket[i] = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            sh_page[i] = '0; sh_pins[i] = '0; sh_dirty[i] = 1'b0;
            sh_prev[i] = 0; sh_next[i] = 0;
        end

        // Directed: absent pages, the unused op code, extreme ids, colliding homes,
        // unpin below zero, dirty marks.
        add_req(OP_UNPIN, 32'h0);
        add_req(OP_DIRTY, 32'hFFFF_FFFF);
        add_req(2'd3, 32'h0);
        add_req(OP_GET, 32'h0);
        add_req(OP_GET, 32'hFFFF_FFFF);
        add_req(OP_GET, 32'h0);
        add_req(OP_GET, 32'h80);
        add_req(OP_GET, 32'h100);
        add_req(OP_DIRTY, 32'h80);
        add_req(OP_UNPIN, 32'h80);
        add_req(OP_UNPIN, 32'h80);
        add_req(OP_UNPIN, 32'h0);
        add_req(OP_UNPIN, 32'h0);
        add_req(OP_UNPIN, 32'h0);
        add_req(2'd3, 32'hFFFF_FFFF);
        add_req(OP_GET, 32'hAAAA_5555);
        add_req(OP_GET, 32'h5555_AAAA);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Get 64 new pages, more than the free and unpinned slots, so the last gets and one more find all pinned.
        for (int i = 0; i < 64; i++) add_req(OP_GET, 32'h1000 + i);
        add_req(OP_GET, 32'h7777_0000);
        // Wait for the queue to drain and everything to come back.
        wait (pending_reqs.size() == 0 && expected_res.size() == 0);
        hold_sender = 1'b1;
        repeat (3) @(posedge i_clk);
        hold_sender = 1'b0;

        // Release pins so evictions start; make some victims dirty.
        add_req(OP_UNPIN, 32'hFFFF_FFFF);
        add_req(OP_UNPIN, 32'hFFFF_FFFF);
        add_req(OP_DIRTY, 32'hFFFF_FFFF);
        for (int i = 0; i < 64; i++) begin
            add_req(OP_UNPIN, 32'h1000 + i);
            if (i % 3 == 0) add_req(OP_DIRTY, 32'h1000 + i);
        end

        // Random part: pages from working sets that alternate between a little and much larger than the slots.
        for (int n = 0; n < 1780; n++) begin
            span = (n % 600 < 300) ? 90 : 300;
            pg = pick_page(span);
            case ($urandom_range(0, 19))
                0: add_req(2'd3, pg);
                1, 2, 3, 4, 5, 6, 7, 8: add_req(OP_GET, pg);
                9, 10, 11, 12, 13, 14, 15: add_req(OP_UNPIN, pg);
                default: add_req(OP_DIRTY, pg);
            endcase
            if (n % 400 == 200) begin
                wait (pending_reqs.size() == 0);
            end
        end
        wait (pending_reqs.size() == 0);
        wait (expected_res.size() == 0);
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Timeout for roughly 1950 requests, with stalls.
    initial begin
        #30ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
